// ===== rtl/cyl2cart_pkg.sv =====
// shared types, fixed-point constants and arctangent table for the
// cylindrical to cartesian converter; no dependencies
package cyl2cart_pkg;

  localparam int STEPS_DEFAULT      = 24;
  localparam int DATA_WIDTH_DEFAULT = 32;
  localparam int MAX_STEPS          = 31;
  localparam int COORD_W            = 32;
  localparam int ANGLE_W            = 32;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;

  // cordic gain in q0.32, angles in q4.28
  localparam logic [31:0]        GAIN_Q32    = 32'd2608131496;
  localparam logic signed [32:0] PI_Q28      = 33'sd843314857;
  localparam logic signed [32:0] HALF_PI_Q28 = 33'sd421657428;
  localparam logic signed [32:0] TWO_PI_Q28  = 33'sd1686629713;

  // atan(2^-idx) in q4.28, rounded to nearest
  function automatic angle_t atan_q28(input int unsigned idx);
    case (idx)
      0:       return angle_t'(210828714);
      1:       return angle_t'(124459457);
      2:       return angle_t'(65760959);
      3:       return angle_t'(33381290);
      4:       return angle_t'(16755422);
      5:       return angle_t'(8385879);
      6:       return angle_t'(4193963);
      7:       return angle_t'(2097109);
      8:       return angle_t'(1048571);
      9:       return angle_t'(524287);
      10:      return angle_t'(262144);
      11:      return angle_t'(131072);
      12:      return angle_t'(65536);
      13:      return angle_t'(32768);
      14:      return angle_t'(16384);
      15:      return angle_t'(8192);
      16:      return angle_t'(4096);
      17:      return angle_t'(2048);
      18:      return angle_t'(1024);
      19:      return angle_t'(512);
      20:      return angle_t'(256);
      21:      return angle_t'(128);
      22:      return angle_t'(64);
      23:      return angle_t'(32);
      24:      return angle_t'(16);
      25:      return angle_t'(8);
      26:      return angle_t'(4);
      27:      return angle_t'(2);
      28:      return angle_t'(1);
      default: return angle_t'(0);
    endcase
  endfunction

endpackage

// ===== rtl/cyl2cart_if.sv =====
// valid/ready channel interfaces for the converter input and result
// depends on cyl2cart_pkg
interface cyl2cart_in_if import cyl2cart_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t radius;
  angle_t angle;
  coord_t height;

  modport source (output valid, output radius, output angle, output height, input ready);
  modport sink   (input valid, input radius, input angle, input height, output ready);
endinterface

interface cyl2cart_out_if import cyl2cart_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t x_out;
  coord_t y_out;
  coord_t z_out;

  modport source (output valid, output x_out, output y_out, output z_out, input ready);
  modport sink   (input valid, input x_out, input y_out, input z_out, output ready);
endinterface

// ===== rtl/cylindrical_to_cartesian_unit.sv =====
// cylindrical to cartesian converter: pre-scale, angle reduction, unrolled cordic
// depends on cyl2cart_pkg and the interfaces in cyl2cart_if.sv
//
//   channel  role    payload                        transfer
//   cyl      sink    radius, angle, height (q16/28) valid & ready
//   cart     source  x_out, y_out, z_out (q16.16)   valid & ready
//
// one item per cycle while the result is not stalled; stages in order: gain multiply and
// angle wrap, rounding and quadrant fold, negate, one cordic step per stage,
// then rounding and saturation into the output register.
// rst clears all stage valid bits; payload registers are not reset.
// each stage holds while its successor is full and stalled, empty stages
// fill, so a stalled result still lets new items enter.
module cylindrical_to_cartesian_unit import cyl2cart_pkg::*; #(
  parameter int CORDIC_STEPS = STEPS_DEFAULT,
  parameter int DATA_WIDTH   = DATA_WIDTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  cyl2cart_in_if.sink     cyl,
  cyl2cart_out_if.source  cart
);

  localparam int FRAC    = DATA_WIDTH - 16;
  localparam int SH      = 48 - FRAC;
  localparam int XW      = DATA_WIDTH + 2;
  localparam int EW      = XW + 17;
  localparam int STAGES  = CORDIC_STEPS + 4;
  localparam int RND_SH  = (FRAC > 16) ? FRAC - 17 : 0;
  localparam int DOWN_SH = (FRAC > 16) ? FRAC - 16 : 0;
  localparam int UP_SH   = (FRAC < 16) ? 16 - FRAC : 0;

  localparam logic signed [64:0]   PRE_HALF  = 65'sd1 <<< (SH - 1);
  localparam logic signed [EW-1:0] POST_HALF = EW'(1) <<< RND_SH;
  localparam logic signed [EW-1:0] SAT_HI    = EW'(64'sd2147483647);
  localparam logic signed [EW-1:0] SAT_LO    = EW'(-64'sd2147483648);

  function automatic coord_t to_q16(input logic signed [XW-1:0] v);
    logic signed [EW-1:0] e;
    logic signed [EW-1:0] q;
    e = {{17{v[XW-1]}}, v};
    if (FRAC > 16) begin
      q = (e + POST_HALF) >>> DOWN_SH;
    end else begin
      q = e <<< UP_SH;
    end
    if (q > SAT_HI) begin
      return coord_t'(32'h7fff_ffff);
    end else if (q < SAT_LO) begin
      return coord_t'(32'h8000_0000);
    end else begin
      return q[COORD_W-1:0];
    end
  endfunction

  // stage valid bits and per-stage enables
  logic [STAGES-1:0] v;
  logic [STAGES-1:0] en;
  logic [STAGES-1:0] v_in;

  assign en[STAGES-1] = ~v[STAGES-1] | cart.ready;
  for (genvar k = 0; k < STAGES - 1; k++) begin : g_en
    assign en[k] = ~v[k] | en[k+1];
  end

  assign v_in      = {v[STAGES-2:0], cyl.valid};
  assign cyl.ready = en[0];
  assign cart.valid = v[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (v & ~en) | (v_in & en);
    end
  end

  // stage a: gain multiply, wrap angle into [-pi, pi]
  logic signed [64:0] prod_a;
  angle_t             ang_a;
  coord_t             z_a;
  logic signed [32:0] ang_ext;
  logic signed [32:0] ang_red;

  always_comb begin
    ang_ext = {cyl.angle[ANGLE_W-1], cyl.angle};
    if (ang_ext > PI_Q28) begin
      ang_red = ang_ext - TWO_PI_Q28;
    end else if (ang_ext < -PI_Q28) begin
      ang_red = ang_ext + TWO_PI_Q28;
    end else begin
      ang_red = ang_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_a <= $signed(cyl.radius) * $signed({1'b0, GAIN_Q32});
      ang_a  <= ang_red[ANGLE_W-1:0];
      z_a    <= cyl.height;
    end
  end

  // stage b: round pre-scaled radius, fold angle into [-pi/2, pi/2]
  logic signed [64:0] prod_rnd;
  logic signed [64:0] prod_sh;
  logic signed [32:0] ang_a_ext;
  logic signed [32:0] ang_fold;
  logic               neg_fold;
  logic signed [XW-1:0] x_b;
  angle_t             ang_b;
  logic               neg_b;
  coord_t             z_b;

  always_comb begin
    prod_rnd  = prod_a + PRE_HALF;
    prod_sh   = prod_rnd >>> SH;
    ang_a_ext = {ang_a[ANGLE_W-1], ang_a};
    if (ang_a_ext > HALF_PI_Q28) begin
      ang_fold = ang_a_ext - PI_Q28;
      neg_fold = 1'b1;
    end else if (ang_a_ext < -HALF_PI_Q28) begin
      ang_fold = ang_a_ext + PI_Q28;
      neg_fold = 1'b1;
    end else begin
      ang_fold = ang_a_ext;
      neg_fold = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x_b   <= prod_sh[XW-1:0];
      ang_b <= ang_fold[ANGLE_W-1:0];
      neg_b <= neg_fold;
      z_b   <= z_a;
    end
  end

  // stage c: start vector, negated for the far half plane
  logic signed [XW-1:0] cx [CORDIC_STEPS+1];
  logic signed [XW-1:0] cy [CORDIC_STEPS+1];
  angle_t               ca [CORDIC_STEPS+1];
  coord_t               cz [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      cx[0] <= neg_b ? -x_b : x_b;
      cy[0] <= '0;
      ca[0] <= ang_b;
      cz[0] <= z_b;
    end
  end

  // one rotation step per stage
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en[3+k]) begin
        if (!ca[k][ANGLE_W-1]) begin
          cx[k+1] <= cx[k] - (cy[k] >>> k);
          cy[k+1] <= cy[k] + (cx[k] >>> k);
          ca[k+1] <= ca[k] - atan_q28(k);
        end else begin
          cx[k+1] <= cx[k] + (cy[k] >>> k);
          cy[k+1] <= cy[k] - (cx[k] >>> k);
          ca[k+1] <= ca[k] + atan_q28(k);
        end
        cz[k+1] <= cz[k];
      end
    end
  end

  // output register: back to q16.16 with saturation
  always_ff @(posedge clk) begin
    if (en[STAGES-1]) begin
      cart.x_out <= to_q16(cx[CORDIC_STEPS]);
      cart.y_out <= to_q16(cy[CORDIC_STEPS]);
      cart.z_out <= cz[CORDIC_STEPS];
    end
  end

endmodule

// ===== rtl/cyl2cart_checker.sv =====
// port-level checks on the converter handshakes, bound to the top level
// depends on cyl2cart_pkg and cylindrical_to_cartesian_unit
module cyl2cart_checker import cyl2cart_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input coord_t x_out,
  input coord_t y_out,
  input coord_t z_out
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // an empty output stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result dropped");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(x_out) && $stable(y_out) && $stable(z_out))
    else $error("stalled result changed");

endmodule

bind cylindrical_to_cartesian_unit cyl2cart_checker u_cyl2cart_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (cyl.ready),
  .out_valid (cart.valid),
  .out_ready (cart.ready),
  .x_out     (cart.x_out),
  .y_out     (cart.y_out),
  .z_out     (cart.z_out)
);
